[rtl/vn_pkg.sv]
// Shared constants and types for the vector normalizer.
`timescale 1ns / 1ps
`default_nettype none
package vn_pkg;
  localparam int FRAC_BITS = 24;
  localparam int IN_W      = 32;
  localparam int SQ_W      = 2 * IN_W;
  localparam int ROOT_W    = IN_W;
  localparam int REM_W     = ROOT_W + 3;
  localparam int TOL_W     = 25;
  localparam int OUT_W     = 26;
  localparam int QW        = FRAC_BITS + 1;
  localparam int DIV_R_W   = ROOT_W + 1;
  localparam int LAT       = 37 + QW;
  localparam logic [TOL_W-1:0] TOL_RESET =
    TOL_W'(((64'd1 << FRAC_BITS) + 64'd50000) / 64'd100000);

  typedef struct packed {
    logic [IN_W-1:0] ax;
    logic [IN_W-1:0] ay;
    logic            sx;
    logic            sy;
  } side_t;
endpackage
`default_nettype wire

[rtl/vn_sqrt.sv]
// Pipelined floor square root, one result bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module vn_sqrt import vn_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              valid_i,
  input  wire logic [SQ_W-1:0]   n_i,
  input  wire side_t             side_i,
  output logic                   valid_o,
  output logic [ROOT_W-1:0]      root_o,
  output side_t                  side_o
);
  logic              v_q    [ROOT_W+1];
  logic [SQ_W-1:0]   n_q    [ROOT_W+1];
  logic [REM_W-1:0]  rem_q  [ROOT_W+1];
  logic [ROOT_W-1:0] root_q [ROOT_W+1];
  side_t             side_q [ROOT_W+1];

  always_comb begin
    v_q[0]    = valid_i;
    n_q[0]    = n_i;
    rem_q[0]  = '0;
    root_q[0] = '0;
    side_q[0] = side_i;
  end

  for (genvar s = 0; s < ROOT_W; s++) begin : g_stage
    logic [REM_W-1:0] rs, t;
    logic             ge;
    always_comb begin
      rs = {rem_q[s][REM_W-3:0], n_q[s][SQ_W-1 -: 2]};
      t  = REM_W'({root_q[s], 2'b01});
      ge = rs >= t;
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s+1] <= 1'b0;
      end else begin
        v_q[s+1] <= v_q[s];
      end
    end
    always_ff @(posedge clk_i) begin
      n_q[s+1]    <= n_q[s] << 2;
      rem_q[s+1]  <= ge ? rs - t : rs;
      root_q[s+1] <= {root_q[s][ROOT_W-2:0], ge};
      side_q[s+1] <= side_q[s];
    end
  end

  assign valid_o = v_q[ROOT_W];
  assign root_o  = root_q[ROOT_W];
  assign side_o  = side_q[ROOT_W];
endmodule
`default_nettype wire

[rtl/vn_div.sv]
// Pipelined restoring divider: (a << FRAC_BITS) / m, one quotient bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module vn_div import vn_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              valid_i,
  input  wire logic [IN_W-1:0]   a_i,
  input  wire logic [ROOT_W-1:0] m_i,
  output logic                   valid_o,
  output logic [QW-1:0]          q_o
);
  logic               v_q [QW+1];
  logic [DIV_R_W-1:0] r_q [QW+1];
  logic [ROOT_W-1:0]  m_q [QW+1];
  logic [QW-1:0]      q_q [QW+1];

  // a >> 1 is already below m; the remaining dividend bits are a[0] then zeros
  always_comb begin
    v_q[0] = valid_i;
    r_q[0] = DIV_R_W'(a_i >> 1);
    m_q[0] = m_i;
    q_q[0] = '0;
  end

  for (genvar s = 0; s < QW; s++) begin : g_stage
    logic [DIV_R_W:0] rs;
    logic             ge;
    always_comb begin
      rs = {r_q[s], (s == 0) ? a_i[0] : 1'b0};
      ge = rs >= (DIV_R_W+1)'(m_q[s]);
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s+1] <= 1'b0;
      end else begin
        v_q[s+1] <= v_q[s];
      end
    end
    always_ff @(posedge clk_i) begin
      r_q[s+1] <= DIV_R_W'(ge ? rs - (DIV_R_W+1)'(m_q[s]) : rs);
      m_q[s+1] <= m_q[s];
      q_q[s+1] <= {q_q[s][QW-2:0], ge};
    end
  end

  assign valid_o = v_q[QW];
  assign q_o     = q_q[QW];
endmodule
`default_nettype wire

[rtl/vector2d_normalize_top.sv]
// Top level of the 2D vector normalizer.
//   channel | direction | handshake       | payload
//   request | in        | start, busy     | in_x_i, in_y_i
//   result  | out       | valid_o strobe  | unit_x_o, unit_y_o, too_small_o
//   config  | in        | cfg_we_i        | cfg_wdata_i (tolerance)
// One request per cycle; results come out in request order.
// Latency is set by the 32-stage square root and the 25-stage dividers.
// busy stays low: the pipeline never stalls and the receiver cannot hold off.
// Reset clears all valid bits and loads the tolerance with its default.
`timescale 1ns / 1ps
`default_nettype none
module vector2d_normalize_top import vn_pkg::*; (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    start,
  output logic                         busy,
  input  wire logic signed [IN_W-1:0]  in_x_i,
  input  wire logic signed [IN_W-1:0]  in_y_i,
  input  wire logic                    cfg_we_i,
  input  wire logic [TOL_W-1:0]        cfg_wdata_i,
  output logic                         valid_o,
  output logic signed [OUT_W-1:0]      unit_x_o,
  output logic signed [OUT_W-1:0]      unit_y_o,
  output logic                         too_small_o
);
  logic [TOL_W-1:0] tol_q;
  logic             v0_q, v1_q, v2_q, v3_q, vout_q;
  side_t            s0_q, s1_q, s2_q, sq_side;
  logic [SQ_W-1:0]  x2_q, y2_q, n_q;
  logic             sq_valid;
  logic [ROOT_W-1:0] root;
  logic [ROOT_W-1:0] div_q;
  logic [IN_W-1:0]  ax3_q, ay3_q;
  logic             dvx, dvy;
  logic [QW-1:0]    qx, qy;
  logic [2:0]       line_q [QW+1];
  logic             tiny_d;

  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= TOL_RESET;
      v0_q  <= 1'b0;
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
      vout_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        tol_q <= cfg_wdata_i;
      end
      v0_q   <= start & ~busy;
      v1_q   <= v0_q;
      v2_q   <= v1_q;
      v3_q   <= sq_valid;
      vout_q <= dvx;
    end
  end

  // magnitudes, squares, sum
  always_ff @(posedge clk_i) begin
    s0_q.sx <= in_x_i[IN_W-1];
    s0_q.sy <= in_y_i[IN_W-1];
    s0_q.ax <= in_x_i[IN_W-1] ? IN_W'(-in_x_i) : in_x_i;
    s0_q.ay <= in_y_i[IN_W-1] ? IN_W'(-in_y_i) : in_y_i;
    x2_q    <= SQ_W'(s0_q.ax) * SQ_W'(s0_q.ax);
    y2_q    <= SQ_W'(s0_q.ay) * SQ_W'(s0_q.ay);
    s1_q    <= s0_q;
    n_q     <= x2_q + y2_q;
    s2_q    <= s1_q;
  end

  vn_sqrt u_sqrt (
    .clk_i, .rst_ni,
    .valid_i (v2_q),
    .n_i     (n_q),
    .side_i  (s2_q),
    .valid_o (sq_valid),
    .root_o  (root),
    .side_o  (sq_side)
  );

  assign tiny_d = (ROOT_W'(tol_q) > root) || (root == '0);

  always_ff @(posedge clk_i) begin
    div_q   <= tiny_d ? ROOT_W'(64'd1 << FRAC_BITS) : root;
    ax3_q   <= sq_side.ax;
    ay3_q   <= sq_side.ay;
    line_q[0] <= {sq_side.sx, sq_side.sy, tiny_d};
  end

  for (genvar s = 0; s < QW; s++) begin : g_line
    always_ff @(posedge clk_i) begin
      line_q[s+1] <= line_q[s];
    end
  end

  vn_div u_div_x (
    .clk_i, .rst_ni,
    .valid_i (v3_q),
    .a_i     (ax3_q),
    .m_i     (div_q),
    .valid_o (dvx),
    .q_o     (qx)
  );

  vn_div u_div_y (
    .clk_i, .rst_ni,
    .valid_i (v3_q),
    .a_i     (ay3_q),
    .m_i     (div_q),
    .valid_o (dvy),
    .q_o     (qy)
  );

  logic [QW-1:0]         qx_z, qy_z;
  logic signed [QW:0]    rx, ry;
  logic [2:0]            ln;

  always_comb begin
    ln   = line_q[QW];
    qx_z = (QW'(tol_q) > qx || ln[0]) ? '0 : qx;
    qy_z = (QW'(tol_q) > qy || ln[0]) ? '0 : qy;
    rx   = ln[2] ? -$signed({1'b0, qx_z}) : $signed({1'b0, qx_z});
    ry   = ln[1] ? -$signed({1'b0, qy_z}) : $signed({1'b0, qy_z});
  end

  always_ff @(posedge clk_i) begin
    unit_x_o    <= OUT_W'(rx);
    unit_y_o    <= OUT_W'(ry);
    too_small_o <= ln[0];
  end

  assign valid_o = vout_q;

  a_tiny_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && too_small_o |-> unit_x_o == '0 && unit_y_o == '0)
    else $error("tiny vector produced nonzero result");
  a_lanes_align: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dvx == dvy) else $error("divider lanes out of step");
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(start && !busy && rst_ni, LAT) |-> valid_o) else $error("result missing");
  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(start, LAT)) else $error("unexpected result");
endmodule
`default_nettype wire

[test/vn_checker.sv]
// Checker for the vector normalizer: predicts each result and compares it.
`timescale 1ns / 1ps
module vn_checker import vn_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  input  logic                    busy,
  input  logic signed [IN_W-1:0]  in_x_i,
  input  logic signed [IN_W-1:0]  in_y_i,
  input  logic                    cfg_we_i,
  input  logic [TOL_W-1:0]        cfg_wdata_i,
  input  logic                    valid_o,
  input  logic signed [OUT_W-1:0] unit_x_o,
  input  logic signed [OUT_W-1:0] unit_y_o,
  input  logic                    too_small_o,
  output int                      fail_count,
  output int                      pending
);
  typedef struct packed {
    logic [OUT_W-1:0] ux;
    logic [OUT_W-1:0] uy;
    logic             small_flag;
  } unit_vec_t;

  unit_vec_t     unit_q[$];
  logic [TOL_W-1:0] tol;

  function automatic logic [63:0] floor_sqrt(input logic [63:0] n);
    logic [63:0] root;
    logic [63:0] rem;
    logic [63:0] bitv;
    root = 0;
    rem = n;
    bitv = 64'd1 << 62;
    while (bitv > rem) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rem >= root + bitv) begin
        rem = rem - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  function automatic logic [OUT_W-1:0] scaled_comp(input logic signed [IN_W-1:0] c,
                                                   input logic [63:0] div);
    logic [63:0] a;
    logic [63:0] q;
    a = c[IN_W-1] ? 64'(-64'(c)) : 64'(c);
    q = (a << FRAC_BITS) / div;
    if (q < 64'(tol)) q = 0;
    if (c[IN_W-1]) q = -q;
    return q[OUT_W-1:0];
  endfunction

  function automatic unit_vec_t normalize(input logic signed [IN_W-1:0] x,
                                          input logic signed [IN_W-1:0] y);
    logic [63:0] ax;
    logic [63:0] ay;
    logic [63:0] m;
    unit_vec_t r;
    ax = x[IN_W-1] ? 64'(-64'(x)) : 64'(x);
    ay = y[IN_W-1] ? 64'(-64'(y)) : 64'(y);
    m = floor_sqrt(ax * ax + ay * ay);
    r.small_flag = (m < 64'(tol)) || (m == 0);
    if (r.small_flag) begin
      r.ux = '0;
      r.uy = '0;
    end else begin
      r.ux = scaled_comp(x, m);
      r.uy = scaled_comp(y, m);
    end
    return r;
  endfunction

  initial begin
    fail_count = 0;
    pending = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    unit_vec_t e;
    if (!rst_ni) begin
      tol = TOL_RESET;
      unit_q.delete();
    end else begin
      if (valid_o) begin
        if (unit_q.size() == 0) begin
          $error("unexpected result x=%0d y=%0d", unit_x_o, unit_y_o);
          fail_count++;
        end else begin
          e = unit_q.pop_front();
          if (unit_x_o !== e.ux) begin
            $error("unit_x expected %0d actual %0d", $signed(e.ux), unit_x_o);
            fail_count++;
          end
          if (unit_y_o !== e.uy) begin
            $error("unit_y expected %0d actual %0d", $signed(e.uy), unit_y_o);
            fail_count++;
          end
          if (too_small_o !== e.small_flag) begin
            $error("too_small expected %0b actual %0b", e.small_flag, too_small_o);
            fail_count++;
          end
        end
      end
      // predict with the tolerance in force before this edge's write
      if (start && !busy) unit_q.push_back(normalize(in_x_i, in_y_i));
      if (cfg_we_i) tol = cfg_wdata_i;
    end
    pending = unit_q.size();
  end
endmodule

[test/testbench.sv]
// Testbench top: drives requests and tolerance writes, gives the verdict.
`timescale 1ns / 1ps
module testbench;
  import vn_pkg::*;

  logic clk_i = 0;
  logic rst_ni = 0;
  logic start = 0;
  logic busy;
  logic signed [IN_W-1:0] in_x_i = '0;
  logic signed [IN_W-1:0] in_y_i = '0;
  logic cfg_we_i = 0;
  logic [TOL_W-1:0] cfg_wdata_i = '0;
  logic valid_o;
  logic signed [OUT_W-1:0] unit_x_o;
  logic signed [OUT_W-1:0] unit_y_o;
  logic too_small_o;
  int fail_count;
  int pending;

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  vector2d_normalize_top u_dut (
    .clk_i, .rst_ni, .start, .busy, .in_x_i, .in_y_i, .cfg_we_i, .cfg_wdata_i,
    .valid_o, .unit_x_o, .unit_y_o, .too_small_o
  );

  vn_checker u_checker (
    .clk_i, .rst_ni, .start, .busy, .in_x_i, .in_y_i, .cfg_we_i, .cfg_wdata_i,
    .valid_o, .unit_x_o, .unit_y_o, .too_small_o, .fail_count, .pending
  );

  // Drive one request; start stays high across back-to-back requests.
  task automatic send_vec(input logic [IN_W-1:0] x, input logic [IN_W-1:0] y,
                          input bit gaps);
    int idle;
    idle = gaps ? $urandom_range(0, 18) : 0;
    if (idle > 0) begin
      start <= 0;
      repeat (idle) @(negedge clk_i);
    end
    start <= 1;
    in_x_i <= x;
    in_y_i <= y;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic drain();
    start <= 0;
    while (pending != 0) @(negedge clk_i);
    repeat (LAT + 5) @(negedge clk_i);
  endtask

  task automatic write_tol(input logic [TOL_W-1:0] v);
    cfg_we_i <= 1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 0;
  endtask

  function automatic logic [IN_W-1:0] rand_comp();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 300) - 150;
      1: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      2: return $urandom_range(0, 1) ? 32'h0100_0000 : 32'hFF00_0000;
      3: return $urandom >> $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  initial begin
    logic [IN_W-1:0] edge_vals[8];
    logic [TOL_W-1:0] tols[5];
    edge_vals = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                  32'h0100_0000, 32'hFF00_0000, 32'h0000_00A8};
    tols = '{25'd0, 25'h100_0000, 25'd1, 25'd168, 25'h0FF_FFFF};
    repeat (6) @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);
    // directed: extremes under the reset tolerance
    for (int i = 0; i < 5; i++)
      for (int j = 0; j < 4; j++) send_vec(edge_vals[i*1+j], edge_vals[7-j-i], 0);
    send_vec(32'd100, 32'd50, 0);
    send_vec(32'd0, 32'd0, 0);
    drain();
    for (int p = 0; p < 6; p++) begin
      write_tol(p < 5 ? tols[p] : 25'($urandom_range(0, 25'h100_0000)));
      send_vec(32'd0, 32'd0, 1);
      send_vec(32'h0100_0000, 32'd0, 1);
      for (int n = 0; n < 240; n++)
        send_vec(rand_comp(), rand_comp(), $urandom_range(0, 3) != 0 || p == 2 ? 1'b1 : 1'b0);
      drain();
    end
    if (fail_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end
endmodule

[files.f]
rtl/vn_pkg.sv
rtl/vn_sqrt.sv
rtl/vn_div.sv
rtl/vector2d_normalize_top.sv
test/vn_checker.sv
test/testbench.sv
